/* design/csuo_pkg.sv */
`timescale 1ns / 1ps
// csuo_pkg: shared types, constants and the arrow shape table for the cursor
// save-under overlay. No dependencies.
package csuo_pkg;

   localparam int PIX_W      = 32;
   localparam int POS_W      = 12;
   localparam int OUT_W      = 14;
   localparam int KIND_W     = 2;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_ADDR_W = 1;
   localparam int Q_DEPTH    = 4;
   localparam int QPTR_W     = $clog2(Q_DEPTH);
   localparam int QCNT_W     = $clog2(Q_DEPTH + 1);
   localparam int SHAPE_ROWS_N = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_FILL    = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_OUTLINE = 1'd1;

   localparam logic [PIX_W-1:0] FILL_RESET    = 32'hFFFF_FFFF;
   localparam logic [PIX_W-1:0] OUTLINE_RESET = 32'h0000_0000;

   typedef enum logic [KIND_W-1:0] {
      KIND_SHOW    = 2'd0,
      KIND_PIXEL   = 2'd1,
      KIND_RESTORE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_CAPTURE,
      PH_SHOWN,
      PH_RESTORE
   } phase_type;

   typedef enum logic [1:0] {
      CLS_SKIP,
      CLS_FILL,
      CLS_OUTLINE,
      CLS_SAVED
   } cls_type;

   typedef struct packed {
      cls_type                 cls;
      logic signed [OUT_W-1:0] wx;
      logic signed [OUT_W-1:0] wy;
      logic                    visible;
      logic                    done;
   } cmd_type;

   typedef struct packed {
      cmd_type          cmd;
      logic [PIX_W-1:0] saved;
   } entry_type;

   // Arrow bitmap, leftmost pixel in bit 7; rows past the arrow are empty.
   localparam logic [7:0] SHAPE_ROWS [SHAPE_ROWS_N] = '{
      8'h80, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC, 8'hFE, 8'hFF,
      8'hF8, 8'hD8, 8'h8C, 8'h0C, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   function automatic logic in_shape(input int c, input int r, input int sw, input int sh);
      logic [4:0] ri;
      logic [2:0] ci;
      ri = r[4:0];
      ci = 3'(7 - c);
      if (r < 0 || r >= sh || r >= SHAPE_ROWS_N || c < 0 || c >= sw || c >= 8) begin
         return 1'b0;
      end
      return SHAPE_ROWS[ri][ci];
   endfunction

endpackage

/* design/cursor_save_under_overlay.sv */
`timescale 1ns / 1ps
// cursor_save_under_overlay: top level of the save-under arrow cursor.
// Uses csuo_pkg, csuo_front, csuo_queue and csuo_back.
//
//  channel | direction | handshake              | payload
//  req_    | in        | req_tvalid/req_tready  | tdata pos_x,pos_y,background; tuser kind
//  rsp_    | out       | rsp_tvalid/rsp_tready  | tdata write..visible; tlast patch_done
//  csr_    | in        | csr_we                 | csr_addr, csr_wdata
//
// One request word per cycle is taken while req_tready is high; the shape lookup and
// save RAM read are registered at the accepting edge, then the word is written into the
// queue and from there into the output register, where it waits for rsp_tready.
// Reset is synchronous and clears phase, counters and queue; RAM
// contents are kept. A stalled rsp_ side fills the four-word queue; req_tready
// drops once the queued words and the staged word together reach four.
module cursor_save_under_overlay
   import csuo_pkg::*;
#(
   parameter int SHAPE_HEIGHT = 12,
   parameter int SHAPE_WIDTH  = 8,
   parameter int COORD_BITS   = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // pos_x[11:0], pos_y[23:12], background[55:24]
   input  logic [KIND_W-1:0]     req_tuser,   // kind[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // write[0], write_x[14:1], write_y[28:15],
                                              // color[60:29], visible[61], zero[63:62]
   output logic                  rsp_tlast,   // patch_done
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [PIX_W-1:0]      csr_wdata
);

   logic [PIX_W-1:0]  fill_ff;
   logic [PIX_W-1:0]  outline_ff;
   logic              push_vld;
   entry_type         push_entry;
   entry_type         head;
   logic [QCNT_W-1:0] q_count;
   logic              pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= FILL_RESET;
         outline_ff <= OUTLINE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FILL:    fill_ff    <= csr_wdata;
            CSR_OUTLINE: outline_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   csuo_front #(
      .SHAPE_HEIGHT (SHAPE_HEIGHT),
      .SHAPE_WIDTH  (SHAPE_WIDTH),
      .COORD_BITS   (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_count    (q_count),
      .push_vld   (push_vld),
      .push_entry (push_entry)
   );

   csuo_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_vld),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .count      (q_count)
   );

   csuo_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_count       (q_count),
      .head          (head),
      .fill_color    (fill_ff),
      .outline_color (outline_ff),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast)
   );

   // Every accepted word reaches the queue in the following cycle.
   a_accept_push: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> push_vld)
      else $error("accepted word did not reach the queue");

   // Credit check: never push into a full queue without a pop.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_vld && !pop |-> q_count != QCNT_W'(Q_DEPTH))
      else $error("queue overflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      q_count <= QCNT_W'(Q_DEPTH))
      else $error("queue count out of range");

endmodule

/* design/csuo_ram.sv */
`timescale 1ns / 1ps
// csuo_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module csuo_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 140
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* design/csuo_front.sv */
`timescale 1ns / 1ps
// csuo_front: accepts request words, tracks the capture/restore phase and the
// patch position, holds the save-under RAM. Uses csuo_pkg and csuo_ram.
module csuo_front
   import csuo_pkg::*;
#(
   parameter int SHAPE_HEIGHT = 12,
   parameter int SHAPE_WIDTH  = 8,
   parameter int COORD_BITS   = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [KIND_W-1:0]     req_tuser,
   input  logic [QCNT_W-1:0]     q_count,
   output logic                  push_vld,
   output entry_type             push_entry
);

   localparam int PATCH_W = SHAPE_WIDTH + 2;
   localparam int PATCH_H = SHAPE_HEIGHT + 2;
   localparam int PATCH_N = PATCH_W * PATCH_H;
   localparam int COL_W   = $clog2(PATCH_W);
   localparam int ROW_W   = $clog2(PATCH_H);
   localparam int IDX_W   = $clog2(PATCH_N);
   localparam int ANCH_W  = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;

   phase_type          phase_ff, phase_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [ANCH_W-1:0]  ax_ff, ax_in;
   logic [ANCH_W-1:0]  ay_ff, ay_in;
   logic               stg_vld_ff;
   cmd_type            stg_cmd_ff;
   cmd_type            cmd;
   logic               accept;
   logic [QCNT_W:0]    used;
   logic               ram_we;
   logic [PIX_W-1:0]   ram_rdata;
   logic [POS_W-1:0]   pos_x;
   logic [POS_W-1:0]   pos_y;
   logic [PIX_W-1:0]   background;
   logic signed [OUT_W-1:0] wx, wy;
   logic               sh_c, sh_l, sh_r, sh_u, sh_d;
   int                 c, r;

   assign pos_x      = req_tdata[POS_W-1:0];
   assign pos_y      = req_tdata[2*POS_W-1:POS_W];
   assign background = req_tdata[2*POS_W+PIX_W-1:2*POS_W];

   // Hold back while the queue could not absorb everything in flight.
   assign used       = {1'b0, q_count} + (QCNT_W+1)'(stg_vld_ff);
   assign req_tready = used < (QCNT_W+1)'(Q_DEPTH);
   assign accept     = req_tvalid && req_tready;

   assign wx = OUT_W'(ax_ff) + OUT_W'(col_ff) - OUT_W'(1);
   assign wy = OUT_W'(ay_ff) + OUT_W'(row_ff) - OUT_W'(1);

   always_comb begin
      c    = int'(col_ff) - 1;
      r    = int'(row_ff) - 1;
      sh_c = in_shape(c, r, SHAPE_WIDTH, SHAPE_HEIGHT);
      sh_l = in_shape(c - 1, r, SHAPE_WIDTH, SHAPE_HEIGHT);
      sh_r = in_shape(c + 1, r, SHAPE_WIDTH, SHAPE_HEIGHT);
      sh_u = in_shape(c, r - 1, SHAPE_WIDTH, SHAPE_HEIGHT);
      sh_d = in_shape(c, r + 1, SHAPE_WIDTH, SHAPE_HEIGHT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         idx_ff     <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         ax_ff      <= '0;
         ay_ff      <= '0;
         stg_vld_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         idx_ff     <= idx_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         ax_ff      <= ax_in;
         ay_ff      <= ay_in;
         stg_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      stg_cmd_ff <= cmd;
   end

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      ram_we   = 1'b0;
      cmd      = '0;
      cmd.cls  = CLS_SKIP;
      if (accept) begin
         case (kind_type'(req_tuser))
            KIND_SHOW: begin
               if (phase_ff == PH_IDLE) begin
                  ax_in    = pos_x[ANCH_W-1:0];
                  ay_in    = pos_y[ANCH_W-1:0];
                  idx_in   = '0;
                  col_in   = '0;
                  row_in   = '0;
                  phase_in = PH_CAPTURE;
               end
            end
            KIND_PIXEL, KIND_RESTORE: begin
               if ((kind_type'(req_tuser) == KIND_PIXEL && phase_ff == PH_CAPTURE) ||
                   (kind_type'(req_tuser) == KIND_RESTORE &&
                    (phase_ff == PH_SHOWN || phase_ff == PH_RESTORE))) begin
                  cmd.wx = wx;
                  cmd.wy = wy;
                  if (kind_type'(req_tuser) == KIND_PIXEL) begin
                     ram_we = 1'b1;
                     if (sh_c) begin
                        cmd.cls = CLS_FILL;
                     end else if (sh_l || sh_r || sh_u || sh_d) begin
                        cmd.cls = CLS_OUTLINE;
                     end
                  end else begin
                     cmd.cls  = CLS_SAVED;
                     phase_in = PH_RESTORE;
                  end
                  // Advance in raster order; wrap to the start after the last pixel.
                  if (idx_ff == IDX_W'(PATCH_N - 1)) begin
                     idx_in   = '0;
                     col_in   = '0;
                     row_in   = '0;
                     cmd.done = 1'b1;
                     phase_in = (kind_type'(req_tuser) == KIND_PIXEL) ? PH_SHOWN : PH_IDLE;
                  end else begin
                     idx_in = idx_ff + IDX_W'(1);
                     if (col_ff == COL_W'(PATCH_W - 1)) begin
                        col_in = '0;
                        row_in = row_ff + ROW_W'(1);
                     end else begin
                        col_in = col_ff + COL_W'(1);
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      cmd.visible = (phase_in == PH_SHOWN) || (phase_in == PH_RESTORE);
   end

   csuo_ram #(
      .WIDTH (PIX_W),
      .DEPTH (PATCH_N)
   ) u_save_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (idx_ff),
      .wdata (background),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   assign push_vld         = stg_vld_ff;
   assign push_entry.cmd   = stg_cmd_ff;
   assign push_entry.saved = ram_rdata;

endmodule

/* design/csuo_queue.sv */
`timescale 1ns / 1ps
// csuo_queue: short FIFO of classified words between front and back.
// Uses csuo_pkg.
module csuo_queue
   import csuo_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  entry_type         push_entry,
   input  logic              pop,
   output entry_type         head,
   output logic [QCNT_W-1:0] count
);

   entry_type           slot_ff [Q_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head  = slot_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

/* design/csuo_back.sv */
`timescale 1ns / 1ps
// csuo_back: picks the pixel colour for each queued word and holds the
// response word until taken. Uses csuo_pkg.
module csuo_back
   import csuo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [QCNT_W-1:0]     q_count,
   input  entry_type             head,
   input  logic [PIX_W-1:0]      fill_color,
   input  logic [PIX_W-1:0]      outline_color,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic                  out_vld_ff;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic                  out_last_ff;
   logic [PIX_W-1:0]      color;
   logic                  write;

   assign pop = (q_count != '0) && (!out_vld_ff || rsp_tready);

   always_comb begin
      case (head.cmd.cls)
         CLS_FILL:    color = fill_color;
         CLS_OUTLINE: color = outline_color;
         CLS_SAVED:   color = head.saved;
         default:     color = '0;
      endcase
      write       = head.cmd.cls != CLS_SKIP;
      out_data_in = {2'b00, head.cmd.visible, color, head.cmd.wy, head.cmd.wx, write};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (pop) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_data_ff <= out_data_in;
         out_last_ff <= head.cmd.done;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

/* bench/tb_cursor_save_under_overlay.sv */
`timescale 1ns / 1ps
// tb_cursor_save_under_overlay: self-checking bench for the save-under arrow cursor.
// Depends on csuo_pkg and cursor_save_under_overlay; keeps its own copy of the cursor
// state, predicts every response word and compares it field by field.
module tb_cursor_save_under_overlay;
   import csuo_pkg::*;

   localparam int PATCH_W     = 10;
   localparam int PATCH_H     = 14;
   localparam int PATCH_N     = PATCH_W * PATCH_H;
   localparam int LATENCY     = 3;
   localparam int CYCLE_LIMIT = 400000;

   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   // Arrow bitmap, leftmost pixel in bit 7.
   localparam logic [7:0] ARROW_ROWS [12] = '{
      8'h80, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC,
      8'hFE, 8'hFF, 8'hF8, 8'hD8, 8'h8C, 8'h0C
   };

   typedef struct packed {
      logic             write;
      logic [OUT_W-1:0] wx;
      logic [OUT_W-1:0] wy;
      logic [PIX_W-1:0] color;
      logic             visible;
      logic             done;
   } cursor_write_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [KIND_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [PIX_W-1:0]      csr_wdata  = '0;

   cursor_save_under_overlay dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // predicted cursor state
   logic [PIX_W-1:0] fill_colour    = FILL_RESET;
   logic [PIX_W-1:0] outline_colour = OUTLINE_RESET;
   bit               drawn          = 1'b0;
   phase_type        ov_phase       = PH_IDLE;
   logic [POS_W-1:0] anchor_x       = '0;
   logic [POS_W-1:0] anchor_y       = '0;
   int               patch_pos      = 0;
   logic [PIX_W-1:0] saved_patch [PATCH_N];

   cursor_write_type writes_due [$];
   int               mismatches = 0;
   int               items_sent = 0;
   int               burst_left = 0;
   int               cycles     = 0;
   int               stall_left = 0;
   int               stall_mode = 0;

   function automatic bit shape_hit(input int c, input int r);
      if (r < 0 || r >= 12 || c < 0 || c >= 8) begin
         return 1'b0;
      end
      return ARROW_ROWS[r][7 - c];
   endfunction

   // {row, column} of a patch pixel, one pixel up and left of the anchor, wrapped to 14 bits
   function automatic logic [2*OUT_W-1:0] patch_coords(input int idx);
      int px;
      int py;
      px = int'(anchor_x) + idx % PATCH_W - 1;
      py = int'(anchor_y) + idx / PATCH_W - 1;
      return {py[OUT_W-1:0], px[OUT_W-1:0]};
   endfunction

   function automatic cursor_write_type predict_cursor_word(input logic [KIND_W-1:0] kind,
                                                            input logic [POS_W-1:0] x,
                                                            input logic [POS_W-1:0] y,
                                                            input logic [PIX_W-1:0] bg);
      cursor_write_type w;
      int c;
      int r;
      w = '0;
      if (kind == KIND_SHOW) begin
         if (ov_phase == PH_IDLE && !drawn) begin
            anchor_x  = x;
            anchor_y  = y;
            patch_pos = 0;
            ov_phase  = PH_CAPTURE;
         end
      end else if (kind == KIND_PIXEL) begin
         if (ov_phase == PH_CAPTURE) begin
            saved_patch[patch_pos] = bg;
            {w.wy, w.wx} = patch_coords(patch_pos);
            c = patch_pos % PATCH_W - 1;
            r = patch_pos / PATCH_W - 1;
            if (shape_hit(c, r)) begin
               w.write = 1'b1;
               w.color = fill_colour;
            end else if (shape_hit(c - 1, r) || shape_hit(c + 1, r) ||
                         shape_hit(c, r - 1) || shape_hit(c, r + 1)) begin
               w.write = 1'b1;
               w.color = outline_colour;
            end
            if (patch_pos == PATCH_N - 1) begin
               patch_pos = 0;
               ov_phase  = PH_SHOWN;
               drawn     = 1'b1;
               w.done    = 1'b1;
            end else begin
               patch_pos++;
            end
         end
      end else if (kind == KIND_RESTORE) begin
         if (drawn && (ov_phase == PH_SHOWN || ov_phase == PH_RESTORE)) begin
            if (ov_phase == PH_SHOWN) begin
               patch_pos = 0;
               ov_phase  = PH_RESTORE;
            end
            w.write = 1'b1;
            {w.wy, w.wx} = patch_coords(patch_pos);
            w.color = saved_patch[patch_pos];
            if (patch_pos == PATCH_N - 1) begin
               patch_pos = 0;
               ov_phase  = PH_IDLE;
               drawn     = 1'b0;
               w.done    = 1'b1;
            end else begin
               patch_pos++;
            end
         end
      end
      w.visible = drawn;
      return w;
   endfunction

   function automatic logic [PIX_W-1:0] rand_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_coord();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return POS_W'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      mismatches++;
   endtask

   task automatic send_word(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] x,
                            input logic [POS_W-1:0] y, input logic [PIX_W-1:0] bg);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {bg, y, x};
      do @(posedge clock); while (!req_tready);
      writes_due.push_back(predict_cursor_word(kind, x, y, bg));
      items_sent++;
   endtask

   task automatic send_stray(input bit allow_show);
      logic [KIND_W-1:0] kind;
      case ($urandom_range(allow_show ? 0 : 1, 3))
         0: kind = KIND_SHOW;
         1: kind = KIND_PIXEL;
         2: kind = KIND_RESTORE;
         default: kind = KIND_SPARE;
      endcase
      send_word(kind, POS_W'($urandom), POS_W'($urandom), $urandom);
   endtask

   // drop valid and hold until every predicted word has come back
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (writes_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 1) @(posedge clock);
   endtask

   task automatic set_colour(input logic [CSR_ADDR_W-1:0] addr, input logic [PIX_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (addr == CSR_FILL) begin
         fill_colour = value;
      end else begin
         outline_colour = value;
      end
   endtask

   task automatic finish_capture(input int noise_pct, input int pause_at);
      while (ov_phase == PH_CAPTURE) begin
         if (patch_pos == pause_at) begin
            wait_idle();
            pause_at = -1;
         end
         if ($urandom_range(0, 99) < noise_pct) begin
            send_stray(1'b1);
         end else begin
            send_word(KIND_PIXEL, POS_W'($urandom), POS_W'($urandom), rand_pixel());
         end
      end
   endtask

   task automatic finish_restore(input int noise_pct);
      while (drawn) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            send_stray(1'b1);
         end else begin
            send_word(KIND_RESTORE, POS_W'($urandom), POS_W'($urandom), $urandom);
         end
      end
   endtask

   task automatic test_stray_words();
      send_word(KIND_PIXEL, '0, '0, '0);
      send_word(KIND_RESTORE, '1, '1, '1);
      send_word(KIND_SPARE, '1, '1, '1);
      send_word(KIND_SPARE, '0, '0, '0);
   endtask

   // far corner with the colours left at their reset values
   task automatic test_reset_colours();
      send_word(KIND_SHOW, '1, '1, rand_pixel());
      finish_capture(0, -1);
   endtask

   // stray words while the cursor is up, a noisy restore, then stray words while idle
   task automatic test_phase_guards();
      send_word(KIND_SHOW, 12'h123, 12'h456, '0);
      send_word(KIND_PIXEL, '1, '1, '1);
      send_word(KIND_SPARE, '0, '0, '0);
      send_word(KIND_RESTORE, '0, '0, '0);
      send_word(KIND_SHOW, 12'hAAA, 12'h555, '1);
      send_word(KIND_PIXEL, '0, '0, '1);
      finish_restore(6);
      send_word(KIND_RESTORE, '1, '1, '1);
      send_word(KIND_PIXEL, '0, '0, '0);
   endtask

   // random colours and anchor, noisy capture with one full drain part way
   task automatic test_random_pass();
      set_colour(CSR_FILL, rand_pixel());
      set_colour(CSR_OUTLINE, rand_pixel());
      repeat ($urandom_range(0, 3)) send_stray(1'b0);
      send_word(KIND_SHOW, pick_coord(), pick_coord(), rand_pixel());
      send_word(KIND_SHOW, 12'h555, 12'hAAA, '1);
      send_word(KIND_RESTORE, '1, '1, '1);
      finish_capture(6, 70);
   endtask

   // receiver: hold ready high, toss a coin, or raise ready only when the stall counter is a multiple of four
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= (stall_left % 4 == 0);
      endcase
   end

   always @(posedge clock) begin
      cursor_write_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (writes_due.size() == 0) begin
            report_mismatch("unexpected word", '0, rsp_tdata);
         end else begin
            want = writes_due.pop_front();
            if (rsp_tdata[0] !== want.write) begin
               report_mismatch("write", want.write, rsp_tdata[0]);
            end
            if (rsp_tdata[14:1] !== want.wx) begin
               report_mismatch("write_x", want.wx, rsp_tdata[14:1]);
            end
            if (rsp_tdata[28:15] !== want.wy) begin
               report_mismatch("write_y", want.wy, rsp_tdata[28:15]);
            end
            if (rsp_tdata[60:29] !== want.color) begin
               report_mismatch("color", want.color, rsp_tdata[60:29]);
            end
            if (rsp_tdata[61] !== want.visible) begin
               report_mismatch("visible", want.visible, rsp_tdata[61]);
            end
            if (rsp_tlast !== want.done) begin
               report_mismatch("patch_done", want.done, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_cursor_save_under_overlay NOT OK");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_stray_words();
      test_reset_colours();
      test_phase_guards();
      test_random_pass();
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_cursor_save_under_overlay OK");
      end else begin
         $display("tb_cursor_save_under_overlay NOT OK");
      end
      $finish;
   end

endmodule

/* files.f */
design/csuo_pkg.sv
design/csuo_ram.sv
design/csuo_front.sv
design/csuo_queue.sv
design/csuo_back.sv
design/cursor_save_under_overlay.sv
bench/tb_cursor_save_under_overlay.sv
